>>> hw/rtl/smat_pkg.sv
package smat_pkg;

  localparam int MAX_DIM     = 8;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int ADDR_W      = 6;
  localparam int DEPTH       = MAX_DIM * MAX_DIM;
  localparam int CNT_W       = 8;
  localparam int ELEM_W      = 16;
  localparam int VALUE_W     = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_MUL = 2'd1,
    MODE_TRN = 2'd2,
    MODE_BAD = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_A_ROWS = 3'd1,
    REG_A_COLS = 3'd2,
    REG_B_ROWS = 3'd3,
    REG_B_COLS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_RUN,
    GEN_ERR
  } gen_state_t;

  typedef struct packed {
    mode_t            mode;
    logic [DIM_W-1:0] ar;
    logic [DIM_W-1:0] ac;
    logic [DIM_W-1:0] br;
    logic [DIM_W-1:0] bc;
  } dims_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              is_b;
    logic [ADDR_W-1:0] addr;
    logic              final_item;
  } q_entry_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_run;
    logic             err;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

>>> hw/rtl/smat_fifo.sv
module smat_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  smat_pkg::q_entry_t push_data,
  input  logic              pop,
  output smat_pkg::q_entry_t pop_data,
  output logic              full,
  output logic              empty
);
  import smat_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/smat_front.sv
module smat_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [smat_pkg::ELEM_W-1:0] element,
  input  smat_pkg::dims_t                 dims,
  input  logic                            cfg_clr,
  input  logic                            queue_full,
  input  logic                            done,
  output logic                            busy,
  output logic                            push,
  output smat_pkg::q_entry_t              push_data
);
  import smat_pkg::*;

  logic [CNT_W-1:0] load_count;
  logic             pend;
  logic [CNT_W-1:0] an;
  logic [CNT_W-1:0] bn;
  logic [CNT_W-1:0] total;
  logic             is_b;
  logic             final_item;
  logic [CNT_W-1:0] b_off;

  assign an    = CNT_W'(dims.ar) * CNT_W'(dims.ac);
  assign bn    = CNT_W'(dims.br) * CNT_W'(dims.bc);
  assign total = (dims.mode == MODE_ADD || dims.mode == MODE_MUL) ? an + bn : an;
  assign is_b  = (load_count >= an);
  assign b_off = load_count - an;
  assign final_item = ({1'b0, load_count} + (CNT_W + 1)'(1)) == {1'b0, total};

  assign busy = pend || queue_full;
  assign push = start && !busy;

  always_comb begin
    push_data.elem       = element;
    push_data.is_b       = is_b;
    push_data.addr       = is_b ? b_off[ADDR_W-1:0] : load_count[ADDR_W-1:0];
    push_data.final_item = final_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pend       <= 1'b0;
    end else begin
      if (cfg_clr) begin
        load_count <= '0;
      end else if (push) begin
        load_count <= final_item ? '0 : load_count + CNT_W'(1);
      end
      if (push && final_item) begin
        pend <= 1'b1;
      end else if (done) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/smat_back.sv
module smat_back (
  input  logic                              clk,
  input  logic                              rst,
  input  smat_pkg::dims_t                   dims,
  input  logic                              q_empty,
  input  smat_pkg::q_entry_t                q_data,
  output logic                              pop,
  output logic                              strobe,
  output logic [smat_pkg::IDX_W-1:0]        row,
  output logic [smat_pkg::IDX_W-1:0]        col,
  output logic signed [smat_pkg::VALUE_W-1:0] value,
  output logic                              status,
  output logic                              last
);
  import smat_pkg::*;

  logic [ELEM_W-1:0] a_mem [DEPTH];
  logic [ELEM_W-1:0] b_mem [DEPTH];

  gen_state_t        state;
  gen_state_t        state_next;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [ADDR_W-1:0] a_ptr;
  logic [ADDR_W-1:0] b_ptr;
  logic [ADDR_W-1:0] a_base;
  logic [DIM_W-1:0]  out_rows;
  logic [DIM_W-1:0]  out_cols;
  logic [DIM_W-1:0]  k_len;
  logic              last_i;
  logic              last_j;
  logic              last_k;
  logic              mismatch;
  logic              start_run;
  tag_t              issue;
  tag_t              s1;
  tag_t              s2;
  logic signed [ELEM_W-1:0]  rd_a;
  logic signed [ELEM_W-1:0]  rd_b;
  logic signed [31:0]        prod;
  logic signed [ELEM_W:0]    sum17;
  logic signed [VALUE_W-1:0] term_next;
  logic signed [VALUE_W-1:0] term;
  logic signed [VALUE_W-1:0] acc;
  logic signed [VALUE_W-1:0] acc_sum;

  always_comb begin
    case (dims.mode)
      MODE_MUL: begin
        out_rows = dims.ar;
        out_cols = dims.bc;
        k_len    = dims.ac;
      end
      MODE_TRN: begin
        out_rows = dims.ac;
        out_cols = dims.ar;
        k_len    = DIM_W'(1);
      end
      default: begin
        out_rows = dims.ar;
        out_cols = dims.ac;
        k_len    = DIM_W'(1);
      end
    endcase
  end

  assign last_i = (i == IDX_W'(out_rows - DIM_W'(1)));
  assign last_j = (j == IDX_W'(out_cols - DIM_W'(1)));
  assign last_k = (k == IDX_W'(k_len - DIM_W'(1)));

  assign mismatch = (dims.mode == MODE_ADD && (dims.ar != dims.br || dims.ac != dims.bc))
                 || (dims.mode == MODE_MUL && dims.ac != dims.br)
                 || (dims.mode == MODE_BAD);

  assign pop       = (state == GEN_IDLE) && !q_empty;
  assign start_run = pop && q_data.final_item;

  always_comb begin
    state_next = state;
    case (state)
      GEN_IDLE: if (start_run) state_next = mismatch ? GEN_ERR : GEN_RUN;
      GEN_RUN:  if (last_k && last_j && last_i) state_next = GEN_IDLE;
      GEN_ERR:  state_next = GEN_IDLE;
      default:  state_next = GEN_IDLE;
    endcase
  end

  always_comb begin
    issue = '0;
    case (state)
      GEN_RUN: begin
        issue.valid    = 1'b1;
        issue.first    = (k == '0);
        issue.last_k   = last_k;
        issue.last_run = last_k && last_j && last_i;
        issue.row      = i;
        issue.col      = j;
      end
      GEN_ERR: begin
        issue.valid    = 1'b1;
        issue.first    = 1'b1;
        issue.last_k   = 1'b1;
        issue.last_run = 1'b1;
        issue.err      = 1'b1;
      end
      default: issue = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GEN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == GEN_IDLE) begin
      i      <= '0;
      j      <= '0;
      k      <= '0;
      a_ptr  <= '0;
      b_ptr  <= '0;
      a_base <= '0;
    end else if (state == GEN_RUN) begin
      case (dims.mode)
        MODE_MUL: begin
          if (!last_k) begin
            k     <= k + IDX_W'(1);
            a_ptr <= a_ptr + ADDR_W'(1);
            b_ptr <= b_ptr + ADDR_W'(dims.bc);
          end else begin
            k <= '0;
            if (!last_j) begin
              j     <= j + IDX_W'(1);
              a_ptr <= a_base;
              b_ptr <= ADDR_W'(j) + ADDR_W'(1);
            end else begin
              j      <= '0;
              i      <= i + IDX_W'(1);
              a_base <= a_base + ADDR_W'(dims.ac);
              a_ptr  <= a_base + ADDR_W'(dims.ac);
              b_ptr  <= '0;
            end
          end
        end
        MODE_TRN: begin
          if (!last_j) begin
            j     <= j + IDX_W'(1);
            a_ptr <= a_ptr + ADDR_W'(dims.ac);
          end else begin
            j     <= '0;
            i     <= i + IDX_W'(1);
            a_ptr <= ADDR_W'(i) + ADDR_W'(1);
          end
        end
        default: begin
          a_ptr <= a_ptr + ADDR_W'(1);
          b_ptr <= b_ptr + ADDR_W'(1);
          if (!last_j) begin
            j <= j + IDX_W'(1);
          end else begin
            j <= '0;
            i <= i + IDX_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !q_data.is_b) a_mem[q_data.addr] <= q_data.elem;
    if (pop && q_data.is_b) b_mem[q_data.addr] <= q_data.elem;
    rd_a <= a_mem[a_ptr];
    rd_b <= b_mem[b_ptr];
  end

  assign prod  = rd_a * rd_b;
  assign sum17 = {rd_a[ELEM_W-1], rd_a} + {rd_b[ELEM_W-1], rd_b};

  always_comb begin
    case (dims.mode)
      MODE_MUL: term_next = VALUE_W'(prod);
      MODE_ADD: term_next = {{15{sum17[ELEM_W]}}, sum17, 8'b0};
      MODE_TRN: term_next = {{16{rd_a[ELEM_W-1]}}, rd_a, 8'b0};
      default:  term_next = '0;
    endcase
    if (s1.err) term_next = '0;
  end

  assign acc_sum = s2.first ? term : acc + term;

  always_ff @(posedge clk) begin
    term <= term_next;
    if (s2.valid) acc <= acc_sum;
    if (s2.valid && s2.last_k) begin
      row    <= s2.row;
      col    <= s2.col;
      value  <= acc_sum;
      status <= s2.err;
      last   <= s2.last_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1     <= '0;
      s2     <= '0;
      strobe <= 1'b0;
    end else begin
      s1     <= issue;
      s2     <= s1;
      strobe <= s2.valid && s2.last_k;
    end
  end

endmodule

>>> hw/rtl/small_matrix_add_mult_transpose_core.sv
// Small matrix engine for matrices up to 8x8 of signed Q8.8 elements. Pulse start with one
// element while busy is low: A row-major, then B row-major (transpose mode loads A only).
// Loading takes one element per cycle while busy stays low, into a two-entry queue in front of the element stores.
// The element that completes the run raises busy; the block then computes and streams the
// result row-major, one element per strobe cycle, which the receiver must take as it comes.
// Add and transpose emit one result per cycle; multiply issues one multiply-accumulate
// per cycle through the single multiplier. The last element passes through the queue,
// the state register, the store read registers, the term register and the output
// registers before the first result. A size mismatch, or mode 3, gives one error
// result (status 1, value 0, last 1). busy drops the cycle after the result marked last.
// Configuration writes (cfg_ready is always high) are meant for idle time; each write to a
// defined register restarts loading. Stores hold no reset value and need no clearing pass.
module small_matrix_add_mult_transpose_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [smat_pkg::ELEM_W-1:0]  element,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smat_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                strobe,
  output logic [smat_pkg::IDX_W-1:0]          row,
  output logic [smat_pkg::IDX_W-1:0]          col,
  output logic signed [smat_pkg::VALUE_W-1:0] value,
  output logic                                status,
  output logic                                last
);
  import smat_pkg::*;

  mode_t            mode;
  logic [DIM_W-1:0] a_rows;
  logic [DIM_W-1:0] a_cols;
  logic [DIM_W-1:0] b_rows;
  logic [DIM_W-1:0] b_cols;
  dims_t            dims;
  logic             cfg_we;
  logic             cfg_clr;
  logic             push;
  q_entry_t         push_data;
  logic             pop;
  q_entry_t         pop_data;
  logic             q_full;
  logic             q_empty;
  logic             done;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_clr   = cfg_we && (cfg_index <= REG_B_COLS);
  assign done      = strobe && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_MUL;
      a_rows <= DIM_W'(1);
      a_cols <= DIM_W'(1);
      b_rows <= DIM_W'(1);
      b_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode   <= mode_t'(cfg_data[1:0]);
        REG_A_ROWS: a_rows <= cfg_data;
        REG_A_COLS: a_cols <= cfg_data;
        REG_B_ROWS: b_rows <= cfg_data;
        REG_B_COLS: b_cols <= cfg_data;
        default:    mode   <= mode;
      endcase
    end
  end

  always_comb begin
    dims.mode = mode;
    dims.ar   = clamp_dim(a_rows);
    dims.ac   = clamp_dim(a_cols);
    dims.br   = clamp_dim(b_rows);
    dims.bc   = clamp_dim(b_cols);
  end

  smat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .element    (element),
    .dims       (dims),
    .cfg_clr    (cfg_clr),
    .queue_full (q_full),
    .done       (done),
    .busy       (busy),
    .push       (push),
    .push_data  (push_data)
  );

  smat_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  smat_back u_back (
    .clk     (clk),
    .rst     (rst),
    .dims    (dims),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .strobe  (strobe),
    .row     (row),
    .col     (col),
    .value   (value),
    .status  (status),
    .last    (last)
  );

`ifndef SYNTH
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result emitted while block not busy");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> last)
    else $error("error result not marked last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("busy held after final result");
`endif

endmodule
